@@ design/imm_pkg.sv @@
// shared constants, types and helpers for the integer matrix multiply block
package imm_pkg;

	localparam int MAX_DIM     = 8;
	localparam int DATA_WIDTH  = 16;
	localparam int IDX_W       = 3;
	localparam int DIM_W       = 4;
	localparam int ELEM_W      = 16;
	localparam int VAL_W       = 35;
	localparam int CFG_IDX_W   = 2;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int PROD_W      = 2 * DATA_WIDTH;
	localparam int EXT_W       = (PROD_W > VAL_W) ? PROD_W : VAL_W;

	typedef enum logic [1:0] {
		MODE_LOAD_LEFT  = 2'd0,
		MODE_LOAD_RIGHT = 2'd1,
		MODE_COMPUTE    = 2'd2,
		MODE_NONE       = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEFT_ROWS  = 2'd0,
		CFG_LEFT_COLS  = 2'd1,
		CFG_RIGHT_ROWS = 2'd2,
		CFG_RIGHT_COLS = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		logic             wr_left;
		logic             wr_right;
		logic             mac;
		logic             first;
		logic             last_k;
		logic             last_elem;
		logic             emit_empty;
		logic [IDX_W-1:0] x;
		logic [IDX_W-1:0] y;
		logic [IDX_W-1:0] k;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
		logic pipe_busy;
	} status_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] v;
		if (r == '0) begin
			v = DIM_W'(1);
		end else if (r > DIM_W'(MAX_DIM)) begin
			v = DIM_W'(MAX_DIM);
		end else begin
			v = r;
		end
		return v;
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
	endfunction

endpackage

@@ design/imm_ctrl.sv @@
// controller: configuration registers, load decode and compute sequencing
module imm_ctrl import imm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic [1:0]           mode,
	input  logic [IDX_W-1:0]     row_index,
	input  logic [IDX_W-1:0]     col_index,
	input  status_t              status,
	output logic                 in_stall,
	output cmd_t                 cmd
);

	state_t           state_q, state_d;
	logic [DIM_W-1:0] left_rows_q, left_cols_q, right_rows_q, right_cols_q;
	logic [DIM_W-1:0] lr, lc, rr, rc;
	logic [IDX_W-1:0] x_q, y_q, k_q;
	logic             in_acc, k_last, y_last, elem_last, mismatch;
	mode_t            in_mode;

	assign lr        = eff_dim(left_rows_q);
	assign lc        = eff_dim(left_cols_q);
	assign rr        = eff_dim(right_rows_q);
	assign rc        = eff_dim(right_cols_q);
	assign mismatch  = (lc != rr);
	assign in_mode   = mode_t'(mode);
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign k_last    = ({1'b0, k_q} == lc - DIM_W'(1));
	assign y_last    = ({1'b0, y_q} == rc - DIM_W'(1));
	assign elem_last = y_last && ({1'b0, x_q} == lr - DIM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rows_q  <= DIM_W'(MAX_DIM);
			left_cols_q  <= DIM_W'(MAX_DIM);
			right_rows_q <= DIM_W'(MAX_DIM);
			right_cols_q <= DIM_W'(MAX_DIM);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LEFT_ROWS:  left_rows_q  <= cfg_data;
				CFG_LEFT_COLS:  left_cols_q  <= cfg_data;
				CFG_RIGHT_ROWS: right_rows_q <= cfg_data;
				CFG_RIGHT_COLS: right_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_acc && in_mode == MODE_COMPUTE) begin
				x_q <= '0;
				y_q <= '0;
				k_q <= '0;
			end else if (state_q == ST_ISSUE && !k_last) begin
				k_q <= k_q + IDX_W'(1);
			end else if (state_q == ST_DRAIN && !status.pipe_busy && !elem_last) begin
				k_q <= '0;
				if (y_last) begin
					y_q <= '0;
					x_q <= x_q + IDX_W'(1);
				end else begin
					y_q <= y_q + IDX_W'(1);
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_mode == MODE_COMPUTE) begin
					state_d = mismatch ? ST_EMPTY : ST_START;
				end
			end
			ST_START: begin
				if (!status.out_busy) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (k_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) state_d = elem_last ? ST_IDLE : ST_START;
			end
			ST_EMPTY: begin
				if (!status.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.x         = x_q;
		cmd.y         = y_q;
		cmd.k         = k_q;
		cmd.first     = (k_q == '0);
		cmd.last_k    = k_last;
		cmd.last_elem = elem_last;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr_left  = in_acc && in_mode == MODE_LOAD_LEFT
					&& ({1'b0, row_index} < lr) && ({1'b0, col_index} < lc);
				cmd.wr_right = in_acc && in_mode == MODE_LOAD_RIGHT
					&& ({1'b0, row_index} < rr) && ({1'b0, col_index} < rc);
			end
			ST_ISSUE: cmd.mac        = 1'b1;
			ST_EMPTY: cmd.emit_empty = !status.out_busy;
			default: ;
		endcase
	end

endmodule

@@ design/imm_datapath.sv @@
// datapath: element stores, multiply-accumulate pipeline and output register
module imm_datapath import imm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic [IDX_W-1:0]         row_index,
	input  logic [IDX_W-1:0]         col_index,
	input  logic signed [ELEM_W-1:0] element_value,
	input  logic                     out_stall,
	output status_t                  status,
	output logic                     out_valid,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic signed [VAL_W-1:0]  out_value,
	output logic                     empty_result,
	output logic                     last
);

	logic signed [DATA_WIDTH-1:0] left_mem  [STORE_DEPTH];
	logic signed [DATA_WIDTH-1:0] right_mem [STORE_DEPTH];

	logic signed [DATA_WIDTH-1:0] a_s1, b_s1;
	logic                         valid_s1, first_s1, last_k_s1, last_elem_s1;
	logic [IDX_W-1:0]             x_s1, y_s1;
	logic signed [PROD_W-1:0]     prod_s2;
	logic                         valid_s2, first_s2, last_k_s2, last_elem_s2;
	logic [IDX_W-1:0]             x_s2, y_s2;
	logic signed [VAL_W-1:0]      acc_q, sum;
	logic signed [EXT_W-1:0]      prod_ext;
	logic                         out_valid_q;
	logic [ADDR_W-1:0]            wr_addr;

	assign wr_addr  = store_addr(row_index, col_index);
	assign prod_ext = EXT_W'(prod_s2);
	assign sum      = first_s2 ? prod_ext[VAL_W-1:0] : acc_q + prod_ext[VAL_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.wr_left)  left_mem[wr_addr]  <= DATA_WIDTH'(element_value);
		if (cmd.wr_right) right_mem[wr_addr] <= DATA_WIDTH'(element_value);
	end

	always_ff @(posedge clk) begin
		if (cmd.mac) begin
			a_s1 <= left_mem[store_addr(cmd.x, cmd.k)];
			b_s1 <= right_mem[store_addr(cmd.k, cmd.y)];
		end
		first_s1     <= cmd.first;
		last_k_s1    <= cmd.last_k;
		last_elem_s1 <= cmd.last_elem;
		x_s1         <= cmd.x;
		y_s1         <= cmd.y;
		prod_s2      <= PROD_W'(a_s1) * PROD_W'(b_s1);
		first_s2     <= first_s1;
		last_k_s2    <= last_k_s1;
		last_elem_s2 <= last_elem_s1;
		x_s2         <= x_s1;
		y_s2         <= y_s1;
		if (valid_s2) acc_q <= sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.mac;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_empty || (valid_s2 && last_k_s2)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_empty) begin
			out_row      <= '0;
			out_col      <= '0;
			out_value    <= '0;
			empty_result <= 1'b1;
			last         <= 1'b1;
		end else if (valid_s2 && last_k_s2) begin
			out_row      <= x_s2;
			out_col      <= y_s2;
			out_value    <= sum;
			empty_result <= 1'b0;
			last         <= last_elem_s2;
		end
	end

	assign out_valid        = out_valid_q;
	assign status.out_busy  = out_valid_q;
	assign status.pipe_busy = valid_s1 || valid_s2;

endmodule

@@ design/integer_matrix_multiply.sv @@
// top level of the integer matrix multiply block
// Usage:
// - configuration: cfg_we writes cfg_data into the dimension register cfg_index
//   (left rows, left cols, right rows, right cols); write only while idle
// - input channel: in_valid / in_stall, a transfer when in_valid and !in_stall;
//   mode selects load left, load right or compute
// - a load transfer writes its element; loads stream one per cycle while idle
// - a compute transfer raises in_stall until the last product element has
//   reached the output register
// - each product element passes through a start state, the inner length on the
//   single multiply-accumulate unit, the multiply stage, the accumulate into the
//   output register and a check that the pipeline has drained
// - a dimension mismatch gives one empty result, last set, once out_valid is low
// - output channel: out_valid / out_stall; a stalled result holds in the output
//   register and the next element is not started until it has been taken
// - loads are taken while a final result still waits in the output register
// - reset: dimensions go to 8, the output is empty, the stores are undefined
//   until written
module integer_matrix_multiply import imm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DIM_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               mode,
	input  logic [IDX_W-1:0]         row_index,
	input  logic [IDX_W-1:0]         col_index,
	input  logic signed [ELEM_W-1:0] element_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic signed [VAL_W-1:0]  out_value,
	output logic                     empty_result,
	output logic                     last
);

	cmd_t    cmd;
	status_t status;

	imm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.mode      (mode),
		.row_index (row_index),
		.col_index (col_index),
		.status    (status),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	imm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.out_stall     (out_stall),
		.status        (status),
		.out_valid     (out_valid),
		.out_row       (out_row),
		.out_col       (out_col),
		.out_value     (out_value),
		.empty_result  (empty_result),
		.last          (last)
	);

endmodule

@@ design/imm_checker.sv @@
// port-level checker for the integer matrix multiply block and its bind
module imm_checker import imm_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [1:0]               mode,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [IDX_W-1:0]         out_row,
	input logic signed [VAL_W-1:0]  out_value,
	input logic                     empty_result,
	input logic                     last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(last))
		else $error("stalled result changed");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_result |-> last && out_value == '0 && out_row == '0)
		else $error("empty result not marked last or not zero");

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_COMPUTE |=> in_stall)
		else $error("compute transfer did not make the block busy");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && !empty_result && !last |-> in_stall)
		else $error("non-final result outside a compute run");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (.*);
